// File: hdl/dsb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Draw sort and batch package
// Shared types and constants for the draw-task sorter and batcher.
// ----------------------------------------------------------------------------
package dsb_pkg;

  localparam int unsigned MaxTasksDefault = 64;
  localparam int unsigned KeyWidth        = 64;

  localparam logic CmdAdd    = 1'b0;
  localparam logic CmdSubmit = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [15:0] material_id;
    logic [15:0] resource_id;
    logic [31:0] depth_key;
    logic        flush;
  } in_item_t;

  typedef struct packed {
    logic [15:0] batch_material;
    logic [15:0] batch_resource;
    logic [5:0]  first_index;
    logic [6:0]  task_count;
    logic        last_batch;
    logic        dropped_any;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle,
    StInsRead,
    StInsCmp,
    StScanRead,
    StScanCmp,
    StEmit
  } state_e;

endpackage
`default_nettype wire

// File: hdl/draw_sort_and_batch.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Draw sort and batch
// Insertion-sorted draw-task store with run-length batch emission.
// ----------------------------------------------------------------------------
// An add walks the sorted store from its top, one entry at a time (memory
// read, then compare and shift-up write), until the new key finds its place.
// A submit scans the store once with the same memory port and the shared
// compare unit (its 32-bit run-key inequality), and emits one batch per run,
// waiting while the output buffer is full and stalled. The store holds
// MAX_TASKS keys in a single-port-write, registered-read memory.
// The block takes no new transaction until the current one is done.
// ----------------------------------------------------------------------------
module draw_sort_and_batch #(
  parameter int unsigned MAX_TASKS = dsb_pkg::MaxTasksDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire dsb_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output dsb_pkg::out_item_t     out_data_o
);

  localparam int unsigned AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);

  logic [dsb_pkg::KeyWidth-1:0] mem_q [MAX_TASKS];
  logic [dsb_pkg::KeyWidth-1:0] rd_q;
  logic [AW-1:0]                rd_addr;
  logic                         rd_en;
  logic [AW-1:0]                wr_addr;
  logic [dsb_pkg::KeyWidth-1:0] wr_data;
  logic                         wr_en;

  dsb_pkg::state_e state_q, state_d;
  logic [CW-1:0] total_q, total_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] pos_q, pos_d;     // insert position / scan index
  logic [CW-1:0] start_q, start_d;
  logic [dsb_pkg::KeyWidth-1:0] key_q, key_d;  // new key / run head key
  logic          flush_q, flush_d;
  dsb_pkg::out_item_t obuf_q, obuf_d;
  logic          ovalid_q, ovalid_d;
  logic          last_q, last_d;

  // Memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // Shared compare unit: 64-bit greater-than, or run-key inequality
  logic key_gt;
  logic run_ne;
  assign key_gt = rd_q > key_q;
  assign run_ne = rd_q[63:32] != key_q[63:32];

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dsb_pkg::StIdle;
      total_q  <= '0;
      ovf_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      total_q  <= total_d;
      ovf_q    <= ovf_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    start_q <= start_d;
    key_q   <= key_d;
    flush_q <= flush_d;
    obuf_q  <= obuf_d;
    last_q  <= last_d;
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    total_d  = total_q;
    ovf_d    = ovf_q;
    pos_d    = pos_q;
    start_d  = start_q;
    key_d    = key_q;
    flush_d  = flush_q;
    obuf_d   = obuf_q;
    ovalid_d = ovalid_q;
    last_d   = last_q;
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = key_q;
    in_stall_o = 1'b1;

    // Drop the output transaction once taken
    if (ovalid_q && !out_stall_i) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      dsb_pkg::StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (in_data_i.cmd == dsb_pkg::CmdAdd) begin
            key_d = {in_data_i.material_id, in_data_i.resource_id, in_data_i.depth_key};
            pos_d = total_q;
            if (total_q == CW'(MAX_TASKS)) begin
              ovf_d = 1'b1;
            end else begin
              state_d = dsb_pkg::StInsRead;
            end
          end else begin
            flush_d = in_data_i.flush;
            start_d = '0;
            pos_d   = '0;
            if (total_q == '0) begin
              if (in_data_i.flush) begin
                ovf_d = 1'b0;
              end
            end else begin
              state_d = dsb_pkg::StScanRead;
            end
          end
        end
      end

      // Read the entry below the hole, or place the key at the bottom
      dsb_pkg::StInsRead: begin
        if (pos_q == '0) begin
          wr_en   = 1'b1;
          wr_addr = AW'(pos_q);
          total_d = total_q + CW'(1);
          state_d = dsb_pkg::StIdle;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(pos_q - CW'(1));
          state_d = dsb_pkg::StInsCmp;
        end
      end

      // Shift the larger entry up, or place the key
      dsb_pkg::StInsCmp: begin
        wr_en   = 1'b1;
        wr_addr = AW'(pos_q);
        if (key_gt) begin
          wr_data = rd_q;
          pos_d   = pos_q - CW'(1);
          state_d = dsb_pkg::StInsRead;
        end else begin
          total_d = total_q + CW'(1);
          state_d = dsb_pkg::StIdle;
        end
      end

      // Read the next entry of the scan
      dsb_pkg::StScanRead: begin
        if (pos_q == total_q) begin
          state_d = dsb_pkg::StEmit;
          last_d  = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(pos_q);
          state_d = dsb_pkg::StScanCmp;
        end
      end

      // Detect a run boundary
      dsb_pkg::StScanCmp: begin
        if (pos_q == '0) begin
          key_d   = rd_q;
          pos_d   = CW'(1);
          state_d = dsb_pkg::StScanRead;
        end else if (run_ne) begin
          last_d  = 1'b0;
          state_d = dsb_pkg::StEmit;
        end else begin
          pos_d   = pos_q + CW'(1);
          state_d = dsb_pkg::StScanRead;
        end
      end

      // Emit one batch when the output buffer is free
      dsb_pkg::StEmit: begin
        if (!ovalid_q || !out_stall_i) begin
          ovalid_d = 1'b1;
          obuf_d.batch_material = key_q[63:48];
          obuf_d.batch_resource = key_q[47:32];
          obuf_d.first_index    = 6'(start_q);
          obuf_d.task_count     = 7'(pos_q - start_q);
          obuf_d.last_batch     = last_q;
          obuf_d.dropped_any    = ovf_q;
          if (last_q) begin
            state_d = dsb_pkg::StIdle;
            if (flush_q) begin
              total_d = '0;
              ovf_d   = 1'b0;
            end
          end else begin
            key_d   = rd_q;
            start_d = pos_q;
            pos_d   = pos_q + CW'(1);
            state_d = dsb_pkg::StScanRead;
          end
        end
      end

      default: state_d = dsb_pkg::StIdle;
    endcase
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = obuf_q;

`ifndef ASSERT_OFF
  // Store count never exceeds capacity
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CW'(MAX_TASKS))
    else $error("task count above capacity");

  // Input is taken only in idle
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != dsb_pkg::StIdle) |-> in_stall_o)
    else $error("input open while busy");

  // An emitted batch always holds at least one task
  a_count_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.task_count != 7'd0))
    else $error("empty batch emitted");
`endif

endmodule
`default_nettype wire

// File: verif/draw_sort_and_batch_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Draw sort and batch testbench
// Drives add and submit transactions with random idling, predicts the sorted
// run-length batches and checks each output transaction against the prediction.
// ----------------------------------------------------------------------------
module draw_sort_and_batch_tb;

  localparam int unsigned Depth = dsb_pkg::MaxTasksDefault;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  dsb_pkg::in_item_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  dsb_pkg::out_item_t out_data_o;

  draw_sort_and_batch #(.MAX_TASKS(Depth)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always #10 clk_i = ~clk_i;

  // Predictor state: sorted key store, count and overflow flag
  logic [63:0]        sorted_keys[$];
  bit                 overflow_flag;
  dsb_pkg::out_item_t batches_due[$];
  dsb_pkg::in_item_t  pending_items[$];
  int                 error_count = 0;
  bit                 stim_done = 1'b0;
  bit                 calm_phase = 1'b0;
  int                 hold_cycles = 0;
  bit                 long_hold_req = 1'b0;

  // Apply one accepted transaction to the predictor
  task automatic predict_batches(input dsb_pkg::in_item_t it);
    logic [63:0] key;
    int pos;
    int start;
    dsb_pkg::out_item_t b;
    if (it.cmd == dsb_pkg::CmdAdd) begin
      key = {it.material_id, it.resource_id, it.depth_key};
      if (sorted_keys.size() < Depth) begin
        pos = sorted_keys.size();
        while (pos > 0 && sorted_keys[pos-1] > key) pos--;
        sorted_keys.insert(pos, key);
      end else begin
        overflow_flag = 1'b1;
      end
    end else begin
      start = 0;
      for (int i = 1; i <= sorted_keys.size(); i++) begin
        if (i == sorted_keys.size() || sorted_keys[i][63:32] != sorted_keys[start][63:32]) begin
          b.batch_material = sorted_keys[start][63:48];
          b.batch_resource = sorted_keys[start][47:32];
          b.first_index    = start[5:0];
          b.task_count     = 7'(i - start);
          b.last_batch     = (i == sorted_keys.size());
          b.dropped_any    = overflow_flag;
          batches_due.push_back(b);
          start = i;
        end
      end
      if (it.flush) begin
        sorted_keys.delete();
        overflow_flag = 1'b0;
      end
    end
  endtask

  // Driver: hold payload while stalled, advance on acceptance
  int in_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_batches(in_data_i);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
          in_gap <= $urandom_range(0, 14);
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data_i <= pending_items.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare against the oldest expected batch
  always @(posedge clk_i) begin
    dsb_pkg::out_item_t exp_b;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (batches_due.size() == 0) begin
          $display("%0t: unexpected batch %p", $time, out_data_o);
          error_count++;
        end else begin
          exp_b = batches_due.pop_front();
          if (out_data_o !== exp_b) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_b, out_data_o);
            error_count++;
          end
        end
      end
      // Stall generation: long hold on request, else random bursts
      if (long_hold_req && hold_cycles == 0) begin
        long_hold_req <= 1'b0;
        hold_cycles <= 400;
        out_stall_i <= 1'b1;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall_i <= (hold_cycles > 1);
      end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
        hold_cycles <= $urandom_range(1, 15);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic dsb_pkg::in_item_t add_item(logic [15:0] m, logic [15:0] r,
                                                 logic [31:0] d);
    dsb_pkg::in_item_t it;
    it.cmd = dsb_pkg::CmdAdd;
    it.material_id = m;
    it.resource_id = r;
    it.depth_key = d;
    it.flush = 1'($urandom);
    return it;
  endfunction

  function automatic dsb_pkg::in_item_t submit_item(logic fl);
    dsb_pkg::in_item_t it;
    it.cmd = dsb_pkg::CmdSubmit;
    it.material_id = 16'($urandom);
    it.resource_id = 16'($urandom);
    it.depth_key = $urandom;
    it.flush = fl;
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid_i) @(posedge clk_i);
  endtask

  // Stimulus
  initial begin
    int n_adds;
    logic [15:0] m_pool[4];
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty submits, extremes, equal keys, ordering
    pending_items.push_back(submit_item(1'b0));
    pending_items.push_back(submit_item(1'b1));
    pending_items.push_back(add_item(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
    pending_items.push_back(add_item(16'h0000, 16'h0000, 32'h0000_0000));
    pending_items.push_back(add_item(16'h0000, 16'h0000, 32'h0000_0000));
    pending_items.push_back(add_item(16'h0000, 16'hFFFF, 32'h0000_0001));
    pending_items.push_back(add_item(16'hFFFF, 16'h0000, 32'h8000_0000));
    pending_items.push_back(add_item(16'h0000, 16'h0000, 32'hFFFF_FFFF));
    pending_items.push_back(submit_item(1'b0));
    pending_items.push_back(add_item(16'h5555, 16'hAAAA, 32'h5555_AAAA));
    pending_items.push_back(submit_item(1'b1));
    pending_items.push_back(add_item(16'hAAAA, 16'h5555, 32'hAAAA_5555));
    pending_items.push_back(submit_item(1'b1));

    // Fill past capacity with a long output hold to back up the block
    for (int i = 0; i < Depth + 3; i++)
      pending_items.push_back(add_item(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                                       $urandom));
    pending_items.push_back(submit_item(1'b0));
    pending_items.push_back(submit_item(1'b1));
    pending_items.push_back(submit_item(1'b0));
    long_hold_req <= 1'b1;
    wait_drained();

    // Random: mostly short add runs from small id pools, then a submit
    n_adds = 0;
    while (n_adds < 40) begin
      foreach (m_pool[k]) m_pool[k] = 16'($urandom);
      if ($urandom_range(0, 5) == 0) begin
        for (int i = 0; i < Depth + 1; i++)
          pending_items.push_back(add_item(m_pool[$urandom_range(0, 1)], m_pool[2], $urandom));
        n_adds += int'(Depth) + 1;
      end else begin
        repeat ($urandom_range(1, 12)) begin
          pending_items.push_back(add_item(m_pool[$urandom_range(0, 3)],
                                           m_pool[$urandom_range(0, 3)],
                                           $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : $urandom));
          n_adds++;
        end
      end
      pending_items.push_back(submit_item($urandom_range(0, 3) != 0));
      if (n_adds > 25) calm_phase = 1'b1;
      wait_drained();
    end
    pending_items.push_back(submit_item(1'b1));
    wait_drained();
    while (batches_due.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    stim_done = 1'b1;
  end

  // Final verdict
  initial begin
    wait (stim_done);
    if (error_count == 0 && batches_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Timeout
  initial begin
    #40000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire

// File: draw_sort_and_batch.f
hdl/dsb_pkg.sv
hdl/draw_sort_and_batch.sv
verif/draw_sort_and_batch_tb.sv
